// ----- rtl/core/ptw_pkg.sv -----
// Shared constants and codes for the page table walk block.
`timescale 1ns / 1ps

package ptw_pkg;

    // Table store sizing
    localparam int NUM_TABLES  = 8;
    localparam int IDX_W       = 9;
    localparam int ENTRIES     = 1 << IDX_W;
    localparam int TBL_W       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int ADDR_W      = TBL_W + IDX_W;
    localparam int STORE_DEPTH = NUM_TABLES * ENTRIES;
    localparam int TNUM_CMP_W  = 7;

    // Field widths
    localparam int DESC_W = 64;
    localparam int VA_W   = 48;
    localparam int PAGE_W = 36;
    localparam int TNUM_W = 3;

    // Action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_XLATE = 1'b1;

    // Descriptor kinds (low two bits)
    localparam logic [1:0] DESC_BLOCK = 2'b01;
    localparam logic [1:0] DESC_TABLE = 2'b11;

    // Fault codes
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_INVALID = 2'd1;
    localparam logic [1:0] FAULT_OUTSIDE = 2'd2;

    // Walk levels
    localparam logic [1:0] LVL_0 = 2'd0;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_2 = 2'd2;
    localparam logic [1:0] LVL_3 = 2'd3;

    typedef logic [ADDR_W-1:0] store_addr_t;

endpackage

// ----- rtl/core/ptw_store.sv -----
// Descriptor store: one write port, one registered read port.
`timescale 1ns / 1ps

module ptw_store (
    input  logic                     clk,
    input  logic                     we,
    input  ptw_pkg::store_addr_t     waddr,
    input  logic [ptw_pkg::DESC_W-1:0] wdata,
    input  logic                     re,
    input  ptw_pkg::store_addr_t     raddr,
    output logic [ptw_pkg::DESC_W-1:0] rdata
);
    import ptw_pkg::*;

    logic [DESC_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/page_table_walk_translate_core.sv -----
// Top level of the four-level page table walk and translate block.
`timescale 1ns / 1ps
//
// Command channel: start is taken at a clock edge where busy is low. With
// action = write, the descriptor lands in table_number/entry_number of the
// store; with action = translate, virt_addr is walked through four levels
// of 4 KiB-granule tables rooted at table 0.
// Result channel: done is high for exactly one cycle with phys_addr, fault,
// fault_level and map_level. Every transaction gives one result.
// Sequence: a write shows its result in the cycle after it is taken and
// busy stays low, so writes can follow every cycle. A translate visits
// each level as an address to the store, then a check of the registered
// read data, and shows its result in the cycle after the last check;
// busy is low while that result is on the ports, so the next
// transaction can be taken then. The registered read of the descriptor
// store sets the walk time.
// cfg_we/cfg_wdata load table_base_page; write it only while idle.
// Reset clears control state and table_base_page; the store contents are
// not cleared and must be written before they are walked.
// The receiver cannot stall: each result is on the ports for one cycle.

module page_table_walk_translate_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  logic [ptw_pkg::TNUM_W-1:0]  table_number,
    input  logic [ptw_pkg::IDX_W-1:0]   entry_number,
    input  logic [ptw_pkg::DESC_W-1:0]  descriptor,
    input  logic [ptw_pkg::VA_W-1:0]    virt_addr,
    input  logic                        cfg_we,
    input  logic [ptw_pkg::PAGE_W-1:0]  cfg_wdata,
    output logic                        done,
    output logic [ptw_pkg::VA_W-1:0]    phys_addr,
    output logic [1:0]                  fault,
    output logic [1:0]                  fault_level,
    output logic [1:0]                  map_level
);
    import ptw_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        lvl_reg, lvl_next;
    logic [TBL_W-1:0]  tbl_reg, tbl_next;
    logic [VA_W-1:0]   va_reg, va_next;
    logic [PAGE_W-1:0] base_reg;
    logic              done_reg, done_next;
    logic [VA_W-1:0]   pa_reg, pa_next;
    logic [1:0]        fault_reg, fault_next;
    logic [1:0]        flvl_reg, flvl_next;
    logic [1:0]        mlvl_reg, mlvl_next;

    logic              accept;
    logic              wr_en;
    store_addr_t       wr_addr;
    logic              rd_en;
    store_addr_t       rd_addr;
    logic [DESC_W-1:0] rd_data;
    logic [IDX_W-1:0]  rd_idx;

    logic [1:0]        kind;
    logic [PAGE_W:0]   page_diff;
    logic              next_ok;

    assign accept  = start && !busy;
    assign wr_en   = accept && (action == ACT_WRITE)
                     && (TNUM_CMP_W'(table_number) < TNUM_CMP_W'(NUM_TABLES));
    assign wr_addr = {TBL_W'(table_number), entry_number};

    always_comb
    begin
        unique case (lvl_reg)
            LVL_0:   rd_idx = va_reg[47:39];
            LVL_1:   rd_idx = va_reg[38:30];
            LVL_2:   rd_idx = va_reg[29:21];
            default: rd_idx = va_reg[20:12];
        endcase
    end

    assign rd_en   = (state_reg == S_READ);
    assign rd_addr = {tbl_reg, rd_idx};

    ptw_store u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (descriptor),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Next table number: descriptor page minus store base, must land in range
    assign kind      = rd_data[1:0];
    assign page_diff = {1'b0, rd_data[47:12]} - {1'b0, base_reg};
    assign next_ok   = !page_diff[PAGE_W]
                       && (page_diff[PAGE_W-1:0] < PAGE_W'(NUM_TABLES));

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        tbl_next   = tbl_reg;
        va_next    = va_reg;
        done_next  = 1'b0;
        pa_next    = pa_reg;
        fault_next = fault_reg;
        flvl_next  = flvl_reg;
        mlvl_next  = mlvl_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        done_next  = 1'b1;
                        pa_next    = '0;
                        fault_next = FAULT_NONE;
                        flvl_next  = LVL_0;
                        mlvl_next  = LVL_0;
                    end
                    else
                    begin
                        va_next    = virt_addr;
                        lvl_next   = LVL_0;
                        tbl_next   = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                pa_next    = '0;
                fault_next = FAULT_NONE;
                flvl_next  = LVL_0;
                mlvl_next  = LVL_0;
                if ((lvl_reg == LVL_1) && (kind == DESC_BLOCK))
                begin
                    pa_next   = {rd_data[47:30], va_reg[29:0]};
                    mlvl_next = LVL_1;
                end
                else if ((lvl_reg == LVL_2) && (kind == DESC_BLOCK))
                begin
                    pa_next   = {rd_data[47:21], va_reg[20:0]};
                    mlvl_next = LVL_2;
                end
                else if (kind != DESC_TABLE)
                begin
                    fault_next = FAULT_INVALID;
                    flvl_next  = lvl_reg;
                end
                else if (lvl_reg == LVL_3)
                begin
                    pa_next   = {rd_data[47:12], va_reg[11:0]};
                    mlvl_next = LVL_3;
                end
                else if (!next_ok)
                begin
                    fault_next = FAULT_OUTSIDE;
                    flvl_next  = lvl_reg;
                end
                else
                begin
                    // advance to the next level
                    done_next  = 1'b0;
                    tbl_next   = page_diff[TBL_W-1:0];
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg   <= lvl_next;
        tbl_reg   <= tbl_next;
        va_reg    <= va_next;
        pa_reg    <= pa_next;
        fault_reg <= fault_next;
        flvl_reg  <= flvl_next;
        mlvl_reg  <= mlvl_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign phys_addr   = pa_reg;
    assign fault       = fault_reg;
    assign fault_level = flvl_reg;
    assign map_level   = mlvl_reg;

endmodule

// ----- rtl/core/ptw_checker.sv -----
// Port-level checks for the page table walk block, bound to the top level.
`timescale 1ns / 1ps

module ptw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        action,
    input logic                        done,
    input logic [ptw_pkg::VA_W-1:0]    phys_addr,
    input logic [1:0]                  fault,
    input logic [1:0]                  fault_level,
    input logic [1:0]                  map_level
);
    import ptw_pkg::*;

    // A result is always shown while the block is free for the next transaction
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A write transaction answers in the next cycle with an all-zero result
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_WRITE)) |=>
            (done && (phys_addr == '0) && (fault == FAULT_NONE)
             && (map_level == LVL_0)))
        else $error("write transaction result wrong");

    // A translate transaction holds the block busy in the following cycle
    a_xlate_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_XLATE)) |=> (busy && !done))
        else $error("translate did not start a walk");

    // A fault carries no mapping
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (fault != FAULT_NONE)) |-> ((phys_addr == '0) && (map_level == LVL_0)))
        else $error("faulting result carries a mapping");

    // A clean result carries no fault level
    a_ok_level: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (fault == FAULT_NONE)) |-> (fault_level == LVL_0))
        else $error("clean result carries a fault level");

endmodule

bind page_table_walk_translate_core ptw_checker u_ptw_checker (.*);
